>>> hw/rtl/pmj_pkg.sv
// ----------------------------------------------------------------------------
// pmj_pkg
// Shared constants, codes and types of the meet/join finder.
// ----------------------------------------------------------------------------
package pmj_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ROW_W        = MAX_ELEMENTS;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_MEET = 2'd1;
    localparam logic [1:0] FUNC_JOIN = 2'd2;

    localparam logic [1:0] STAT_FOUND = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic en;
        idx_t row;
        row_t bits;
    } mem_wr_t;

    typedef struct packed {
        idx_t addr_a;
        idx_t addr_b;
    } mem_rd_t;

endpackage

>>> hw/rtl/pmj_req_if.sv
// ----------------------------------------------------------------------------
// pmj_req_if
// Request channel: load or query items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmj_req_if;
    import pmj_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] func;
    idx_t       row_index;
    row_t       row_bits;
    idx_t       first_element;
    idx_t       second_element;

    modport source (
        output valid, func, row_index, row_bits, first_element, second_element,
        input  ready
    );

    modport sink (
        input  valid, func, row_index, row_bits, first_element, second_element,
        output ready
    );
endinterface

>>> hw/rtl/pmj_rsp_if.sv
// ----------------------------------------------------------------------------
// pmj_rsp_if
// Result channel: bound index and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmj_rsp_if;
    import pmj_pkg::*;

    logic       valid;
    logic       ready;
    idx_t       bound_index;
    logic [1:0] status;

    modport source (
        output valid, bound_index, status,
        input  ready
    );

    modport sink (
        input  valid, bound_index, status,
        output ready
    );
endinterface

>>> hw/rtl/pmj_order_mem.sv
// ----------------------------------------------------------------------------
// pmj_order_mem
// Less-or-equal matrix: one write port, two registered read ports, with a
// valid bit per row so that unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module pmj_order_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  pmj_pkg::mem_wr_t wr,
    input  pmj_pkg::mem_rd_t rd,
    output pmj_pkg::row_t    rd_a_data,
    output pmj_pkg::row_t    rd_b_data
);
    import pmj_pkg::*;

    row_t                    mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] row_valid_reg;
    row_t                    rd_a_reg;
    row_t                    rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.en)
        begin
            row_valid_reg[wr.row] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row] <= wr.bits;
        end
        rd_a_reg <= row_valid_reg[rd.addr_a] ? mem[rd.addr_a] : '0;
        rd_b_reg <= row_valid_reg[rd.addr_b] ? mem[rd.addr_b] : '0;
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

>>> hw/rtl/pmj_scan_ctrl.sv
// ----------------------------------------------------------------------------
// pmj_scan_ctrl
// Query sequencer: range, equality and direct-order checks, then a scan over
// the elements in use through one shared compare unit with a candidate stack.
// ----------------------------------------------------------------------------
module pmj_scan_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    pmj_req_if.sink          req,
    pmj_rsp_if.source        rsp,
    input  pmj_pkg::cnt_t    count,
    output pmj_pkg::mem_wr_t mem_wr,
    output pmj_pkg::mem_rd_t mem_rd,
    input  pmj_pkg::row_t    rd_a_data,
    input  pmj_pkg::row_t    rd_b_data
);
    import pmj_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       is_join_reg, is_join_next;
    idx_t       x_reg, x_next;
    idx_t       y_reg, y_next;
    cnt_t       count_reg, count_next;
    row_t       row_x_reg, row_x_next;
    row_t       row_y_reg, row_y_next;
    idx_t       d_reg, d_next;
    idx_t       best_reg, best_next;
    logic       best_valid_reg, best_valid_next;
    cnt_t       depth_reg, depth_next;
    idx_t       pend_idx_reg, pend_idx_next;
    logic [1:0] pend_stat_reg, pend_stat_next;
    logic       res_valid_reg, res_valid_next;
    idx_t       res_idx_reg, res_idx_next;
    logic [1:0] res_stat_reg, res_stat_next;
    idx_t       top_reg;

    idx_t       stack_mem [MAX_ELEMENTS];
    logic       push_en;
    idx_t       push_val;

    logic       accept;
    logic       cand;
    logic       d_le_b;
    logic       b_le_d;
    logic       d_better;
    logic       b_better;
    logic       x_le_y;
    logic       y_le_x;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign mem_wr.en   = accept && (req.func == FUNC_LOAD);
    assign mem_wr.row  = req.row_index;
    assign mem_wr.bits = req.row_bits;

    // Rows x and y during setup, candidate and current best during the scan
    assign mem_rd.addr_a = (state_reg == ST_SETUP) ? x_reg : d_reg;
    assign mem_rd.addr_b = (state_reg == ST_SETUP) ? y_reg : best_reg;

    assign x_le_y = rd_a_data[y_reg];
    assign y_le_x = rd_b_data[x_reg];

    // Shared compare unit: rd_a_data holds row d, rd_b_data row best
    assign cand     = is_join_reg ? (row_x_reg[d_reg] & row_y_reg[d_reg])
                                  : (rd_a_data[x_reg] & rd_a_data[y_reg]);
    assign d_le_b   = rd_a_data[best_reg];
    assign b_le_d   = rd_b_data[d_reg];
    assign d_better = is_join_reg ? (d_le_b & ~b_le_d) : (b_le_d & ~d_le_b);
    assign b_better = is_join_reg ? (b_le_d & ~d_le_b) : (d_le_b & ~b_le_d);

    always_comb
    begin
        state_next      = state_reg;
        is_join_next    = is_join_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        count_next      = count_reg;
        row_x_next      = row_x_reg;
        row_y_next      = row_y_reg;
        d_next          = d_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        depth_next      = depth_reg;
        pend_idx_next   = pend_idx_reg;
        pend_stat_next  = pend_stat_reg;
        res_valid_next  = res_valid_reg && !rsp.ready;
        res_idx_next    = res_idx_reg;
        res_stat_next   = res_stat_reg;
        push_en         = 1'b0;
        push_val        = d_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.func == FUNC_MEET || req.func == FUNC_JOIN))
                begin
                    is_join_next = (req.func == FUNC_JOIN);
                    x_next       = req.first_element;
                    y_next       = req.second_element;
                    count_next   = count;
                    if ({1'b0, req.first_element} >= count
                        || {1'b0, req.second_element} >= count)
                    begin
                        pend_idx_next  = '0;
                        pend_stat_next = STAT_RANGE;
                        state_next     = ST_EMIT;
                    end
                    else if (req.first_element == req.second_element)
                    begin
                        pend_idx_next  = req.first_element;
                        pend_stat_next = STAT_FOUND;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                row_x_next = rd_a_data;
                row_y_next = rd_b_data;
                if (x_le_y && !y_le_x)
                begin
                    pend_idx_next  = is_join_reg ? y_reg : x_reg;
                    pend_stat_next = STAT_FOUND;
                    state_next     = ST_EMIT;
                end
                else if (y_le_x && !x_le_y)
                begin
                    pend_idx_next  = is_join_reg ? x_reg : y_reg;
                    pend_stat_next = STAT_FOUND;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    d_next          = '0;
                    depth_next      = '0;
                    best_next       = '0;
                    best_valid_next = 1'b0;
                    state_next      = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (cand)
                begin
                    priority if (!best_valid_reg)
                    begin
                        best_next       = d_reg;
                        best_valid_next = 1'b1;
                    end
                    else if (b_better)
                    begin
                        push_en  = 1'b1;
                        push_val = d_reg;
                    end
                    else if (d_better)
                    begin
                        push_en   = 1'b1;
                        push_val  = best_reg;
                        best_next = d_reg;
                    end
                    else if (depth_reg == '0)
                    begin
                        best_next       = '0;
                        best_valid_next = 1'b0;
                    end
                    else
                    begin
                        // Drop both, fall back to the popped candidate
                        depth_next = depth_reg - 1'b1;
                        best_next  = top_reg;
                    end
                end
                if (push_en && depth_reg < CNT_W'(MAX_ELEMENTS))
                begin
                    depth_next = depth_reg + 1'b1;
                end
                if ({1'b0, d_reg} == count_reg - 1'b1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                pend_idx_next  = best_valid_reg ? best_reg : '0;
                pend_stat_next = best_valid_reg ? STAT_FOUND : STAT_NONE;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || rsp.ready)
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = pend_idx_reg;
                    res_stat_next  = pend_stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            best_valid_reg <= 1'b0;
            depth_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            best_valid_reg <= best_valid_next;
            depth_reg      <= depth_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_join_reg   <= is_join_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        count_reg     <= count_next;
        row_x_reg     <= row_x_next;
        row_y_reg     <= row_y_next;
        d_reg         <= d_next;
        best_reg      <= best_next;
        pend_idx_reg  <= pend_idx_next;
        pend_stat_reg <= pend_stat_next;
        res_idx_reg   <= res_idx_next;
        res_stat_reg  <= res_stat_next;
    end

    // Candidate stack; the top is fetched while the rows are being read
    always_ff @(posedge clk)
    begin
        if (push_en && depth_reg < CNT_W'(MAX_ELEMENTS))
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= push_val;
        end
        top_reg <= stack_mem[depth_reg[IDX_W-1:0] - IDX_W'(1)];
    end

    assign rsp.valid       = res_valid_reg;
    assign rsp.bound_index = res_idx_reg;
    assign rsp.status      = res_stat_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("candidate stack depth beyond capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> ({1'b0, d_reg} < count_reg))
        else $error("scan index beyond element count");

    a_check_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_SETUP))
        else $error("row check without row fetch");

    a_no_bound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_FOUND) |-> (rsp.bound_index == '0))
        else $error("nonzero bound index with failing status");

endmodule

>>> hw/rtl/poset_meet_join_finder.sv
// ----------------------------------------------------------------------------
// poset_meet_join_finder
// Meet and join finder over a partial order held as a less-or-equal matrix.
// ----------------------------------------------------------------------------
// A load request writes one matrix row in the cycle it is accepted. A query
// answers from the operands alone when one is out of range or both are equal,
// from the row check when one operand lies below the other, and otherwise
// after a scan over the N elements in use: each element passes a read state
// for the registered read of its row and the current best row from the
// matrix memory, and an evaluate state for the shared compare unit and the
// candidate stack. No new request is taken while a query is in progress, but
// a result waiting in the output register does not hold off the next request.
module poset_meet_join_finder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pmj_pkg::CNT_W-1:0]  cfg_wdata,
    pmj_req_if.sink                    req,
    pmj_rsp_if.source                  rsp
);
    import pmj_pkg::*;

    cnt_t    element_count_reg;
    cnt_t    count_eff;
    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    row_t    rd_a_data;
    row_t    rd_b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= CNT_W'(MAX_ELEMENTS);
        end
        else if (cfg_we)
        begin
            element_count_reg <= cfg_wdata;
        end
    end

    // Clamp to capacity
    assign count_eff = (element_count_reg > CNT_W'(MAX_ELEMENTS))
                     ? CNT_W'(MAX_ELEMENTS) : element_count_reg;

    pmj_order_mem u_order_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (mem_wr),
        .rd        (mem_rd),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    pmj_scan_ctrl u_scan_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .count     (count_eff),
        .mem_wr    (mem_wr),
        .mem_rd    (mem_rd),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

endmodule

>>> tb/tb_poset_meet_join_finder.sv
// ----------------------------------------------------------------------------
// tb_poset_meet_join_finder
// Self-checking bench for the meet/join finder: loads order matrices (random
// partial orders, relabeled boolean lattices and raw noise), fires meet and
// join requests under random stalls on both channels, and checks every answer
// against a bit-true predictor of the bound search kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_poset_meet_join_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import pmj_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         N_PHASES    = 26;
    localparam int         DRAIN_WAIT  = 48;

    typedef struct packed {
        logic [1:0] func;
        idx_t       row;
        row_t       bits;
        idx_t       a;
        idx_t       b;
    } request_t;

    typedef struct packed {
        idx_t       bound;
        logic [1:0] status;
    } answer_t;

    class bound_tracker;
        row_t        order_rows[MAX_ELEMENTS];
        logic [4:0]  element_count = 5'd16;
        answer_t     expected_answers[$];
        int unsigned mismatches;
        int unsigned loads_seen;
        int unsigned answers_checked;
        int unsigned n_found;
        int unsigned n_none;
        int unsigned n_range;
        int unsigned n_settings;

        function new();
            foreach (order_rows[i])
                order_rows[i] = '0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void set_count(logic [4:0] v);
            element_count = v;
            n_settings++;
        endfunction

        function bit below(int r, int c);
            return order_rows[r][c];
        endfunction

        // Scan all elements in use, keeping the best bound and a stack of
        // displaced candidates.
        function answer_t scan_bound(int eff, int x, int y, bit is_join);
            int      stack[$];
            int      best;
            bit      have;
            bit      cand;
            bit      d_le_b;
            bit      b_le_d;
            bit      d_better;
            bit      b_better;
            answer_t r;
            best = 0;
            have = 1'b0;
            for (int d = 0; d < eff; d++)
            begin
                cand = is_join ? (below(x, d) && below(y, d))
                               : (below(d, x) && below(d, y));
                if (!cand)
                    continue;
                if (!have)
                begin
                    best = d;
                    have = 1'b1;
                    continue;
                end
                d_le_b   = below(d, best);
                b_le_d   = below(best, d);
                d_better = is_join ? (d_le_b && !b_le_d) : (b_le_d && !d_le_b);
                b_better = is_join ? (b_le_d && !d_le_b) : (d_le_b && !b_le_d);
                if (b_better)
                begin
                    if (stack.size() < MAX_ELEMENTS)
                        stack.push_back(d);
                end
                else if (d_better)
                begin
                    if (stack.size() < MAX_ELEMENTS)
                        stack.push_back(best);
                    best = d;
                end
                else if (stack.size() == 0)
                begin
                    // incomparable with nothing to fall back on: drop both
                    have = 1'b0;
                    best = 0;
                end
                else
                    best = stack.pop_back();
            end
            r.bound  = have ? idx_t'(best) : '0;
            r.status = have ? STAT_FOUND : STAT_NONE;
            return r;
        endfunction

        function answer_t find_bound(logic [1:0] func, idx_t a, idx_t b);
            int      eff;
            bit      a_le_b;
            bit      b_le_a;
            answer_t r;
            eff      = (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : element_count;
            r.bound  = '0;
            r.status = STAT_RANGE;
            if (int'(a) >= eff || int'(b) >= eff)
                return r;
            r.status = STAT_FOUND;
            a_le_b   = below(a, b);
            b_le_a   = below(b, a);
            if (a == b)
                r.bound = a;
            else if (a_le_b && !b_le_a)
                r.bound = (func == FUNC_MEET) ? a : b;
            else if (b_le_a && !a_le_b)
                r.bound = (func == FUNC_MEET) ? b : a;
            else
                r = scan_bound(eff, a, b, func == FUNC_JOIN);
            return r;
        endfunction

        function void note_request(request_t q);
            answer_t r;
            case (q.func)
                FUNC_LOAD:
                begin
                    order_rows[q.row] = q.bits;
                    loads_seen++;
                end
                FUNC_MEET, FUNC_JOIN:
                begin
                    r = find_bound(q.func, q.a, q.b);
                    expected_answers.push_back(r);
                    case (r.status)
                        STAT_FOUND: n_found++;
                        STAT_NONE:  n_none++;
                        default:    n_range++;
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void check_answer(idx_t bound, logic [1:0] status);
            answer_t e;
            answers_checked++;
            if (expected_answers.size() == 0)
            begin
                flag($sformatf("unexpected answer bound=%0d status=%0d", bound, status));
                return;
            end
            e = expected_answers.pop_front();
            if (bound !== e.bound || status !== e.status)
                flag($sformatf("answer #%0d: expected bound=%0d status=%0d, got bound=%0d status=%0d",
                               answers_checked, e.bound, e.status, bound, status));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    bit         stall_en = 1'b1;
    row_t       plan[MAX_ELEMENTS];
    int         cur_count = 16;

    bound_tracker sb = new();

    pmj_req_if req_ch ();
    pmj_rsp_if rsp_ch ();

    poset_meet_join_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("poset_meet_join_finder regression: fail");
        $finish;
    end

    // result side: random ready bursts, check at the rising edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (stall_en && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_answer(rsp_ch.bound_index, rsp_ch.status);
    end

    task automatic send_request(input request_t q);
        if (stall_en && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.func           = q.func;
        req_ch.row_index      = q.row;
        req_ch.row_bits       = q.bits;
        req_ch.first_element  = q.a;
        req_ch.second_element = q.b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(q);
        @(negedge clk);
    endtask

    task automatic issue(input logic [1:0] f, input int r, input int bits,
                         input int a, input int b);
        request_t q;
        q.func = f;
        q.row  = idx_t'(r);
        q.bits = row_t'(bits);
        q.a    = idx_t'(a);
        q.b    = idx_t'(b);
        send_request(q);
    endtask

    // drop valid, wait for every answer, then let a full scan time pass
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (sb.expected_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_count(input logic [4:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_count(v);
        cur_count = v;
    endtask

    function automatic void shuffle(ref int perm[MAX_ELEMENTS]);
        int j;
        int t;
        foreach (perm[i])
            perm[i] = i;
        for (int i = MAX_ELEMENTS - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endfunction

    // kind 0: random partial order, 1: relabeled boolean lattice, 2: noise
    function automatic void build_order(int kind);
        int perm[MAX_ELEMENTS];
        int dens;
        shuffle(perm);
        foreach (plan[i])
            plan[i] = '0;
        case (kind)
            0:
            begin
                dens = $urandom_range(5, 60);
                for (int i = 0; i < MAX_ELEMENTS; i++)
                begin
                    plan[perm[i]][perm[i]] = 1'b1;
                    for (int j = i + 1; j < MAX_ELEMENTS; j++)
                        if ($urandom_range(0, 99) < dens)
                            plan[perm[i]][perm[j]] = 1'b1;
                end
                for (int k = 0; k < MAX_ELEMENTS; k++)
                    for (int i = 0; i < MAX_ELEMENTS; i++)
                        if (plan[i][k])
                            plan[i] |= plan[k];
            end
            1:
            begin
                for (int s = 0; s < MAX_ELEMENTS; s++)
                    for (int t = 0; t < MAX_ELEMENTS; t++)
                        if ((s & t) == s)
                            plan[perm[s]][perm[t]] = 1'b1;
            end
            default:
                foreach (plan[i])
                    plan[i] = row_t'($urandom);
        endcase
    endfunction

    function automatic request_t pick_query();
        request_t q;
        int       eff;
        eff    = (cur_count > MAX_ELEMENTS) ? MAX_ELEMENTS : cur_count;
        q.func = $urandom_range(0, 1) ? FUNC_MEET : FUNC_JOIN;
        q.row  = idx_t'($urandom);
        q.bits = row_t'($urandom);
        if (eff == 0 || $urandom_range(0, 9) == 0)
        begin
            q.a = idx_t'($urandom);
            q.b = idx_t'($urandom);
        end
        else
        begin
            q.a = idx_t'($urandom_range(0, eff - 1));
            q.b = idx_t'($urandom_range(0, eff - 1));
            // favor incomparable pairs so that most requests run the full scan
            if ($urandom_range(0, 9) < 7)
                for (int t = 0; t < 8 && (plan[q.a][q.b] || plan[q.b][q.a]); t++)
                begin
                    q.a = idx_t'($urandom_range(0, eff - 1));
                    q.b = idx_t'($urandom_range(0, eff - 1));
                end
        end
        return q;
    endfunction

    function automatic logic [4:0] pick_count();
        case ($urandom_range(0, 15))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd31;
            3:       return 5'($urandom_range(17, 30));
            4, 5:    return 5'($urandom_range(2, 15));
            default: return 5'd16;
        endcase
    endfunction

    task automatic run_phase();
        int       order[MAX_ELEMENTS];
        int       r;
        request_t q;
        write_count(pick_count());
        build_order($urandom_range(0, 99) < 45 ? 0 : ($urandom_range(0, 99) < 65 ? 1 : 2));
        shuffle(order);
        foreach (order[i])
            issue(FUNC_LOAD, order[i], plan[order[i]], $urandom, $urandom);
        for (int n = 0; n < 40; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                issue(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
            else if (r < 8)
            begin
                q.row       = idx_t'($urandom);
                q.bits      = row_t'($urandom);
                plan[q.row] = q.bits;
                issue(FUNC_LOAD, q.row, q.bits, $urandom, $urandom);
            end
            else
                send_request(pick_query());
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        req_ch.valid          = 1'b0;
        req_ch.func           = FUNC_LOAD;
        req_ch.row_index      = '0;
        req_ch.row_bits       = '0;
        req_ch.first_element  = '0;
        req_ch.second_element = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // cleared matrix: equal operands answer themselves, others have no bound
        issue(FUNC_MEET, 0, 0, 0, 0);
        issue(FUNC_MEET, 0, 0, 3, 5);
        // diamond 0 < 1,2 < 3, and 0 < 4,5 < 6,7 with 4,5 and 6,7 unrelated
        issue(FUNC_LOAD, 0, 16'hFFFF, 0, 0);
        issue(FUNC_LOAD, 1, 16'h000A, 0, 0);
        issue(FUNC_LOAD, 2, 16'h000C, 0, 0);
        issue(FUNC_LOAD, 3, 16'h0008, 0, 0);
        issue(FUNC_LOAD, 4, 16'h00D0, 0, 0);
        issue(FUNC_LOAD, 5, 16'h00E0, 0, 0);
        issue(FUNC_LOAD, 6, 16'h0040, 0, 0);
        issue(FUNC_LOAD, 7, 16'h0080, 0, 0);
        issue(FUNC_LOAD, 15, 16'h0000, 0, 0);
        issue(FUNC_MEET, 0, 0, 1, 2);
        issue(FUNC_JOIN, 0, 0, 1, 2);
        issue(FUNC_MEET, 0, 0, 0, 3);
        issue(FUNC_JOIN, 0, 0, 3, 0);
        // push the bottom, then pop it back on an incomparable candidate
        issue(FUNC_MEET, 0, 0, 6, 7);
        // two incomparable upper bounds with an empty stack
        issue(FUNC_JOIN, 0, 0, 4, 5);
        issue(FUNC_UNUSED, 15, 16'hFFFF, 15, 15);
        issue(FUNC_JOIN, 0, 0, 15, 15);
        write_count(5'd4);
        issue(FUNC_MEET, 0, 0, 15, 0);
        issue(FUNC_JOIN, 0, 0, 2, 4);
        write_count(5'd0);
        issue(FUNC_MEET, 0, 0, 0, 0);
        write_count(5'd31);
        issue(FUNC_JOIN, 0, 0, 1, 2);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p >= N_PHASES - 3)
                stall_en = 1'b0;
            run_phase();
        end

        wait_drained();
        if (sb.expected_answers.size() != 0)
            sb.flag($sformatf("%0d answers never arrived", sb.expected_answers.size()));
        $display("Covered %0d row loads and %0d answers over %0d count settings.",
                 sb.loads_seen, sb.answers_checked, sb.n_settings);
        $display("Answers predicted: %0d found, %0d without bound, %0d out of range; %0d mismatches.",
                 sb.n_found, sb.n_none, sb.n_range, sb.mismatches);
        if (sb.mismatches == 0)
            $display("poset_meet_join_finder regression: pass");
        else
            $display("poset_meet_join_finder regression: fail");
        $finish;
    end

endmodule

>>> poset_meet_join_finder.f
hw/rtl/pmj_pkg.sv
hw/rtl/pmj_req_if.sv
hw/rtl/pmj_rsp_if.sv
hw/rtl/pmj_order_mem.sv
hw/rtl/pmj_scan_ctrl.sv
hw/rtl/poset_meet_join_finder.sv
tb/tb_poset_meet_join_finder.sv
